/* rtl/core/tick_rsi_slope_direction_top_defines.svh */
// assertion macros shared by the rsi slope direction rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef TICK_RSI_SLOPE_DIRECTION_TOP_DEFINES_SVH
`define TICK_RSI_SLOPE_DIRECTION_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TRSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TRSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/trsd_pkg.sv */
// shared types and fixed-format constants for the rsi slope direction block
// no dependencies; imported by trsd_rsi_div and the top level
`timescale 1ns / 1ps

package trsd_pkg;

  // register widths and apb geometry
  localparam int unsigned PERIOD_W = 7;
  localparam int unsigned ALPHA_W  = 17;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // result field widths
  localparam int unsigned RSI_W   = 15;
  localparam int unsigned SLOPE_W = 16;
  localparam int unsigned DIR_W   = 2;

  // register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd30;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd11916;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd16384;
  localparam logic [THRESH_W-1:0] CEIL_RESET   = 16'd61440;

  // rsi scale: 100 in q7.8 is 25 shifted up by 10
  localparam logic [RSI_W-1:0] RSI_FULL  = 15'd25600;
  localparam logic [RSI_W-1:0] RSI_RESET = 15'd12800;
  localparam int unsigned      RSI_MUL_W = 5;
  localparam logic [RSI_MUL_W-1:0] RSI_MUL = 5'd25;
  localparam int unsigned      RSI_SHIFT = 10;
  localparam int unsigned      DCNT_W    = $clog2(RSI_W);

  // slope and ema arithmetic
  localparam logic [SLOPE_W-1:0] DELTA_LIMIT = 16'd1280;
  localparam int unsigned        SLOPE_SHIFT = 4;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam int unsigned        ALPHA_FRAC  = 16;
  localparam int unsigned        DIFF_W      = 17;
  localparam int unsigned        ACC_W       = 34;
  localparam int unsigned        MCNT_W      = $clog2(ALPHA_W);
  localparam logic [ACC_W-1:0]   ROUND_HALF  = 34'd32768;

  // register map
  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_ALPHA  = 2'd1,
    REG_THRESH = 2'd2,
    REG_CEIL   = 2'd3
  } reg_idx_e;

  // direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 2'd0,
    DIR_RISE = 2'd1,
    DIR_FALL = 2'd2
  } dir_e;

endpackage

/* rtl/core/trsd_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module trsd_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/trsd_rsi_div.sv */
// rsi unit: builds 25600*gain+total/2 one multiplier bit a cycle, then a
// restoring divide by the total, one quotient bit a cycle; uses trsd_pkg
`timescale 1ns / 1ps

module trsd_rsi_div #(
  parameter int unsigned SUM_W = 38
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  // both sums must be held stable by the caller until done_o; this unit does not enforce it
  input  logic [SUM_W-1:0]          gain_sum_i,
  input  logic [SUM_W-1:0]          total_i,
  output logic                      done_o,
  output logic [trsd_pkg::RSI_W-1:0] rsi_o
);

  import trsd_pkg::*;

  localparam int unsigned NUM_W = SUM_W + RSI_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_HALF = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;

  logic [1:0]           ph_q, ph_d;
  logic [NUM_W-1:0]     n_q, n_d;
  logic [NUM_W-1:0]     d_q, d_d;
  logic [RSI_MUL_W-1:0] cm_q, cm_d;
  logic [DCNT_W-1:0]    cnt_q, cnt_d;
  logic [RSI_W-1:0]     quo_q, quo_d;
  logic                 done_q, done_d;
  logic                 fits;

  assign fits = (n_q >= d_q);

  // sequencer: constant multiply, half-total add, then divide
  always_comb begin
    ph_d   = ph_q;
    n_d    = n_q;
    d_d    = d_q;
    cm_d   = cm_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    unique case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          n_d   = '0;
          cm_d  = RSI_MUL;
          cnt_d = DCNT_W'(RSI_MUL_W - 1);
          ph_d  = PH_MUL;
        end
      end
      PH_MUL: begin
        n_d   = {n_q[NUM_W-2:0], 1'b0} + (cm_q[RSI_MUL_W-1] ? NUM_W'(gain_sum_i) : '0);
        cm_d  = {cm_q[RSI_MUL_W-2:0], 1'b0};
        cnt_d = cnt_q - DCNT_W'(1);
        if (cnt_q == '0) begin
          ph_d = PH_HALF;
        end
      end
      PH_HALF: begin
        n_d   = (n_q << RSI_SHIFT) + NUM_W'(total_i >> 1);
        d_d   = NUM_W'(total_i) << (RSI_W - 1);
        cnt_d = DCNT_W'(RSI_W - 1);
        quo_d = '0;
        ph_d  = PH_DIV;
      end
      PH_DIV: begin
        if (fits) begin
          n_d = n_q - d_q;
        end
        quo_d = {quo_q[RSI_W-2:0], fits};
        d_d   = d_q >> 1;
        cnt_d = cnt_q - DCNT_W'(1);
        if (cnt_q == '0) begin
          done_d = 1'b1;
          ph_d   = PH_IDLE;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    cm_q  <= cm_d;
    cnt_q <= cnt_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign rsi_o  = quo_q;

endmodule

/* rtl/core/tick_rsi_slope_direction_top.sv */
// channel  | direction | handshake              | payload
// in       | sink      | in_valid_i/in_stall_o   | mid_price_i
// out      | source    | out_valid_o/out_stall_i | rsi_value_o smoothed_slope_o is_warm_o
//          |           |                        | direction_o
// apb      | slave     | psel/penable/pready     | paddr pwrite pwdata prdata
//
// one item at a time: the first stored price goes straight to emit, a change while
// the window fills runs sub, add and check, and a full window may add the 5-step constant
// multiply and 15-step divide in trsd_rsi_div, then the 17-step ema multiply
// reset is asynchronous, active low; the window ram needs no clearing pass
// a waiting result sits in the output register while the next item is taken;
// only the final load of a result waits on out_stall_i
// depends on trsd_pkg, trsd_ram, trsd_rsi_div and the assertion macro header
`timescale 1ns / 1ps
`include "tick_rsi_slope_direction_top_defines.svh"

module tick_rsi_slope_direction_top #(
  parameter int unsigned MAX_PERIOD  = 64,
  parameter int unsigned PRICE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [PRICE_WIDTH-1:0]            mid_price_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [trsd_pkg::RSI_W-1:0]        rsi_value_o,
  output logic signed [trsd_pkg::SLOPE_W-1:0] smoothed_slope_o,
  output logic                              is_warm_o,
  output logic [trsd_pkg::DIR_W-1:0]        direction_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [trsd_pkg::ADDR_W-1:0]       paddr,
  input  logic [trsd_pkg::DATA_W-1:0]       pwdata,
  output logic [trsd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  import trsd_pkg::*;

  localparam int unsigned SUM_W = PRICE_WIDTH + $clog2(MAX_PERIOD);
  localparam int unsigned CNT_W = $clog2(MAX_PERIOD + 1);
  localparam int unsigned PTR_W = $clog2(MAX_PERIOD);
  localparam int unsigned ENT_W = PRICE_WIDTH + 1;
  localparam logic [CNT_W-1:0] PMax = CNT_W'(MAX_PERIOD);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUB   = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_DIVW  = 4'd4;
  localparam logic [3:0] S_SLOPE = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ROUND = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  // configuration registers
  logic [PERIOD_W-1:0] period_q;
  logic [ALPHA_W-1:0]  alpha_q;
  logic [THRESH_W-1:0] thresh_q;
  logic [THRESH_W-1:0] ceil_q;
  logic                cfg_we;
  logic                period_we;

  // control and window state
  logic [3:0]             state_q, state_d;
  logic [PRICE_WIDTH-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [PTR_W-1:0]       ptr_q, ptr_d;
  logic [PTR_W-1:0]       wptr_q, wptr_d;
  logic [SUM_W-1:0]       gsum_q, gsum_d;
  logic [SUM_W-1:0]       lsum_q, lsum_d;
  logic [PRICE_WIDTH-1:0] new_mag_q, new_mag_d;
  logic                   new_gain_q, new_gain_d;
  logic                   full_q, full_d;

  // rsi and slope state
  logic [RSI_W-1:0]   rsi_q, rsi_d;
  logic [RSI_W-1:0]   rsi_new_q, rsi_new_d;
  logic [SLOPE_W-1:0] slope_q, slope_d;
  logic               warm_q, warm_d;
  logic [DIFF_W-1:0]  diff_q, diff_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [ALPHA_W-1:0] alpha_sh_q, alpha_sh_d;
  logic [MCNT_W-1:0]  mcnt_q, mcnt_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [RSI_W-1:0]   out_rsi_q;
  logic [SLOPE_W-1:0] out_slope_q;
  logic               out_warm_q;
  logic [DIR_W-1:0]   out_dir_q;
  logic               out_load;

  // combinational helpers
  logic               in_xfer;
  logic [CNT_W-1:0]   p_act;
  logic [CNT_W-1:0]   ptr_eff;
  logic [CNT_W-1:0]   ptr_inc;
  logic               ram_we;
  logic [ENT_W-1:0]   ram_rdata;
  logic               div_start;
  logic               div_done;
  logic [RSI_W-1:0]   div_rsi;
  logic [SLOPE_W-1:0] delta;
  logic [SLOPE_W-1:0] delta_c;
  logic [SLOPE_W-1:0] slope_new;
  logic [ACC_W-1:0]   acc_rnd;
  logic [ALPHA_W-1:0] alpha_c;
  dir_e               dir_now;

  // apb register file
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;
  assign period_we = cfg_we && (reg_idx_e'(paddr[3:2]) == REG_PERIOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      alpha_q  <= ALPHA_RESET;
      thresh_q <= THRESH_RESET;
      ceil_q   <= CEIL_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_PERIOD: period_q <= pwdata[PERIOD_W-1:0];
        REG_ALPHA:  alpha_q  <= pwdata[ALPHA_W-1:0];
        REG_THRESH: thresh_q <= pwdata[THRESH_W-1:0];
        REG_CEIL:   ceil_q   <= pwdata[THRESH_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_PERIOD: prdata = DATA_W'(period_q);
      REG_ALPHA:  prdata = DATA_W'(alpha_q);
      REG_THRESH: prdata = DATA_W'(thresh_q);
      REG_CEIL:   prdata = DATA_W'(ceil_q);
      default:    prdata = '0;
    endcase
  end

  // active period, zero acts as one and large values saturate
  always_comb begin
    if (period_q == '0) begin
      p_act = CNT_W'(1);
    end else if (32'(period_q) > 32'(MAX_PERIOD)) begin
      p_act = PMax;
    end else begin
      p_act = CNT_W'(period_q);
    end
  end

  // ring position for this change and the one after it
  assign ptr_eff = (CNT_W'(ptr_q) >= p_act) ? '0 : CNT_W'(ptr_q);
  assign ptr_inc = ptr_eff + CNT_W'(1);

  // clamped alpha and direction bands
  assign alpha_c = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

  always_comb begin
    logic [THRESH_W:0] s17;
    logic [THRESH_W:0] t17;
    logic [THRESH_W:0] c17;
    s17 = {slope_q[SLOPE_W-1], slope_q};
    t17 = {1'b0, thresh_q};
    c17 = {1'b0, ceil_q};
    dir_now = DIR_NONE;
    if (warm_q) begin
      if ($signed(s17) > $signed(t17) && $signed(s17) < $signed(c17)) begin
        dir_now = DIR_RISE;
      end else if ($signed(s17) < $signed(-t17) && $signed(s17) > $signed(-c17)) begin
        dir_now = DIR_FALL;
      end
    end
  end

  // rsi change clamped to five points and moved to q3.12
  assign delta = {1'b0, rsi_new_q} - {1'b0, rsi_q};
  always_comb begin
    if ($signed(delta) > $signed(DELTA_LIMIT)) begin
      delta_c = DELTA_LIMIT;
    end else if ($signed(delta) < $signed(-DELTA_LIMIT)) begin
      delta_c = -DELTA_LIMIT;
    end else begin
      delta_c = delta;
    end
  end
  assign slope_new = delta_c << SLOPE_SHIFT;

  // round half up of the ema step
  assign acc_rnd = acc_q + ROUND_HALF;

  assign in_xfer  = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // item sequencer
  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    gsum_d      = gsum_q;
    lsum_d      = lsum_q;
    new_mag_d   = new_mag_q;
    new_gain_d  = new_gain_q;
    full_d      = full_q;
    rsi_d       = rsi_q;
    rsi_new_d   = rsi_new_q;
    slope_d     = slope_q;
    warm_d      = warm_q;
    diff_d      = diff_q;
    acc_d       = acc_q;
    alpha_sh_d  = alpha_sh_q;
    mcnt_d      = mcnt_q;
    ram_we      = 1'b0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          prev_d = mid_price_i;
          if (prev_q == '0) begin
            // first price only stored
            state_d = S_EMIT;
          end else begin
            new_gain_d = mid_price_i > prev_q;
            new_mag_d  = (mid_price_i > prev_q) ? mid_price_i - prev_q
                                                : prev_q - mid_price_i;
            wptr_d  = PTR_W'(ptr_eff);
            ptr_d   = (ptr_inc >= p_act) ? '0 : PTR_W'(ptr_inc);
            full_d  = fill_q >= p_act;
            state_d = S_SUB;
          end
        end
      end
      S_SUB: begin
        // retire the oldest entry or grow the window
        if (full_q) begin
          if (ram_rdata[ENT_W-1]) begin
            gsum_d = gsum_q - SUM_W'(ram_rdata[PRICE_WIDTH-1:0]);
          end else begin
            lsum_d = lsum_q - SUM_W'(ram_rdata[PRICE_WIDTH-1:0]);
          end
        end else begin
          fill_d = fill_q + CNT_W'(1);
        end
        ram_we  = 1'b1;
        state_d = S_ADD;
      end
      S_ADD: begin
        if (new_gain_q) begin
          gsum_d = gsum_q + SUM_W'(new_mag_q);
        end else begin
          lsum_d = lsum_q + SUM_W'(new_mag_q);
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        if (fill_q >= p_act) begin
          if (lsum_q == '0) begin
            rsi_new_d = RSI_FULL;
            state_d   = S_SLOPE;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIVW;
          end
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          rsi_new_d = div_rsi;
          state_d   = S_SLOPE;
        end
      end
      S_SLOPE: begin
        rsi_d = rsi_new_q;
        if (!warm_q) begin
          // first slope seeds the average
          slope_d = slope_new;
          warm_d  = 1'b1;
          state_d = S_EMIT;
        end else begin
          diff_d     = {slope_new[SLOPE_W-1], slope_new} - {slope_q[SLOPE_W-1], slope_q};
          acc_d      = '0;
          alpha_sh_d = alpha_c;
          mcnt_d     = MCNT_W'(ALPHA_W - 1);
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        // alpha msb first, one bit a cycle
        acc_d = {acc_q[ACC_W-2:0], 1'b0}
              + (alpha_sh_q[ALPHA_W-1] ? {{(ACC_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q} : '0);
        alpha_sh_d = {alpha_sh_q[ALPHA_W-2:0], 1'b0};
        mcnt_d     = mcnt_q - MCNT_W'(1);
        if (mcnt_q == '0) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        slope_d = slope_q + acc_rnd[ALPHA_FRAC+SLOPE_W-1:ALPHA_FRAC];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a new period empties the window
    if (period_we) begin
      fill_d = '0;
      ptr_d  = '0;
      gsum_d = '0;
      lsum_d = '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      fill_q      <= '0;
      ptr_q       <= '0;
      gsum_q      <= '0;
      lsum_q      <= '0;
      rsi_q       <= RSI_RESET;
      slope_q     <= '0;
      warm_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      gsum_q      <= gsum_d;
      lsum_q      <= lsum_d;
      rsi_q       <= rsi_d;
      slope_q     <= slope_d;
      warm_q      <= warm_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    wptr_q     <= wptr_d;
    new_mag_q  <= new_mag_d;
    new_gain_q <= new_gain_d;
    full_q     <= full_d;
    rsi_new_q  <= rsi_new_d;
    diff_q     <= diff_d;
    acc_q      <= acc_d;
    alpha_sh_q <= alpha_sh_d;
    mcnt_q     <= mcnt_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsi_q   <= rsi_q;
      out_slope_q <= slope_q;
      out_warm_q  <= warm_q;
      out_dir_q   <= dir_now;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign rsi_value_o      = out_rsi_q;
  assign smoothed_slope_o = out_slope_q;
  assign is_warm_o        = out_warm_q;
  assign direction_o      = out_dir_q;

  // change window: gain flag over magnitude
  trsd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PERIOD)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i ({new_gain_q, new_mag_q}),
    .raddr_i (PTR_W'(ptr_eff)),
    .rdata_o (ram_rdata)
  );

  // serial rsi unit
  trsd_rsi_div #(
    .SUM_W (SUM_W)
  ) u_rsi_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .gain_sum_i (gsum_q),
    .total_i    (gsum_q + lsum_q),
    .done_o     (div_done),
    .rsi_o      (div_rsi)
  );

  // checks on the sequencer and datapath
  `TRSD_ASSERT_NXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q != S_IDLE, "accepted transfer did not start work")
  `TRSD_ASSERT_IMP(a_fill_in_period, clk_i, rst_ni, 1'b1, fill_q <= p_act, "window fill above active period")
  `TRSD_ASSERT_IMP(a_rsi_in_range, clk_i, rst_ni, div_done, div_rsi <= RSI_FULL, "rsi quotient above full scale")
  `TRSD_ASSERT_IMP(a_cold_no_direction, clk_i, rst_ni, out_valid_o && !is_warm_o, direction_o == DIR_NONE, "direction given before warm")

endmodule
